// File: hw/rtl/abkf_pkg.sv
// Package for the angle/bias Kalman filter: widths, formats, register codes.
// Used by abkf_mul, abkf_div and the top level angle_bias_kalman_filter.
`timescale 1ns / 1ps
package abkf_pkg;
  localparam int unsigned ANGLE_FRAC_BITS_DEF = 16;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned DT_W    = 16;
  localparam int unsigned NOISE_W = 24;
  localparam int unsigned DT_FRAC  = 16;
  localparam int unsigned COV_FRAC = 24;
  localparam int unsigned ACC_W    = 72;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_NOISE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS_NOISE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MEASURE_NOISE = 2'd2;

  localparam logic [NOISE_W-1:0] ANGLE_NOISE_RST   = 24'd16777;
  localparam logic [NOISE_W-1:0] BIAS_NOISE_RST    = 24'd50332;
  localparam logic [NOISE_W-1:0] MEASURE_NOISE_RST = 24'd83886;

  typedef logic signed [ACC_W-1:0] acc_t;

  // Saturate a wide signed value to signed 32 bits.
  function automatic logic signed [DATA_W-1:0] sat32(input acc_t v);
    if (v > acc_t'(32'sh7FFFFFFF))       sat32 = 32'sh7FFFFFFF;
    else if (v < -acc_t'(64'sh80000000)) sat32 = 32'sh80000000;
    else                                 sat32 = v[DATA_W-1:0];
  endfunction
endpackage

// File: hw/rtl/abkf_mul.sv
// Bit-serial signed multiplier: 40 x 40 bit product, one multiplier bit a cycle.
// Depends on abkf_pkg.
`timescale 1ns / 1ps
module abkf_mul (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic signed [39:0]    op_a,
  input  logic signed [39:0]    op_b,
  output logic                  done,
  output abkf_pkg::acc_t        prod
);
  import abkf_pkg::*;

  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  acc_t        acc_r, acc_nxt;
  acc_t        mcand_r, mcand_nxt;
  logic [39:0] mplier_r, mplier_nxt;

  // Shift and add; the last (sign) bit of the multiplier subtracts.
  always_comb begin
    cnt_nxt    = cnt_r;
    busy_nxt   = busy_r;
    done_nxt   = 1'b0;
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    if (start) begin
      busy_nxt   = 1'b1;
      cnt_nxt    = '0;
      acc_nxt    = '0;
      mcand_nxt  = acc_t'(op_a);
      mplier_nxt = op_b;
    end else if (busy_r) begin
      if (mplier_r[0]) begin
        if (cnt_r == 6'd39) acc_nxt = acc_r - mcand_r;
        else                acc_nxt = acc_r + mcand_r;
      end
      mcand_nxt  = mcand_r <<< 1;
      mplier_nxt = mplier_r >> 1;
      cnt_nxt    = cnt_r + 6'd1;
      if (cnt_r == 6'd39) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;
endmodule

// File: hw/rtl/abkf_div.sv
// Radix-2 restoring divider for the gains: (num << 24) / den, truncated toward
// zero, one quotient bit a cycle. Depends on abkf_pkg.
`timescale 1ns / 1ps
module abkf_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic signed [31:0]    num,
  input  logic signed [33:0]    den,
  output logic                  done,
  output logic signed [31:0]    quot
);
  import abkf_pkg::*;

  localparam int unsigned QW = 56;

  logic [5:0]    cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [QW-1:0] q_r, q_nxt;
  logic [34:0]   rem_r, rem_nxt;
  logic [33:0]   dmag_r, dmag_nxt;
  logic          neg_r, neg_nxt;
  logic          zero_r, zero_nxt;
  logic [34:0]   trial;
  logic [QW:0]   qs;

  always_comb begin
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dmag_nxt = dmag_r;
    neg_nxt  = neg_r;
    zero_nxt = zero_r;
    trial    = '0;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      q_nxt    = {(num[31] ? 32'(-num) : 32'(num)), 24'd0};
      dmag_nxt = den[33] ? 34'(-den) : 34'(den);
      neg_nxt  = num[31] ^ den[33];
      zero_nxt = (den == '0);
    end else if (busy_r) begin
      // Shift in one dividend bit and try the subtract.
      trial = {rem_r[33:0], q_r[QW-1]} - {1'b0, dmag_r};
      if (!trial[34]) begin
        rem_nxt = trial;
        q_nxt   = {q_r[QW-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[33:0], q_r[QW-1]};
        q_nxt   = {q_r[QW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'(QW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r    <= q_nxt;
    rem_r  <= rem_nxt;
    dmag_r <= dmag_nxt;
    neg_r  <= neg_nxt;
    zero_r <= zero_nxt;
  end

  // Apply sign, saturate; zero divisor gives zero gain.
  assign qs   = neg_r ? -{1'b0, q_r} : {1'b0, q_r};
  assign done = done_r;
  assign quot = zero_r ? 32'sd0 : sat32(acc_t'($signed(qs)));
endmodule

// File: hw/rtl/angle_bias_kalman_filter.sv
// Two-state angle/gyro-bias Kalman filter, one shared bit-serial multiplier
// and one bit-serial divider. Each input item runs through ten multiply
// steps, two divide steps and the S_Y and S_OUT steps. The input is ready
// again in the cycle after the result register loads, and no new item is
// taken while one is in work; the result register frees the input side.
// Synchronous active-low reset clears state, covariance and control and
// loads the noise registers with their defaults.
`timescale 1ns / 1ps
module angle_bias_kalman_filter #(
  parameter int unsigned ANGLE_FRAC_BITS = abkf_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [31:0] measured_angle, [63:32] gyro_rate, [79:64] time_step
  input  logic [79:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [31:0] angle_estimate, [63:32] bias_estimate
  output logic [63:0] out_tdata,
  input  logic        cfg_we,
  input  logic [abkf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [abkf_pkg::NOISE_W-1:0]   cfg_data
);
  import abkf_pkg::*;

  // Fraction bits only set units; the arithmetic is the same for any value.
  localparam logic [4:0] FRAC_TAG = 5'(ANGLE_FRAC_BITS);

  // K1 covariance products run before K0 covariance products so they see P00 and P01 before correction.
  localparam logic [4:0] S_IDLE = 5'd0,  S_RATE = 5'd1,  S_DTP11 = 5'd2,
                         S_INNER = 5'd3, S_P11 = 5'd4,   S_DIV0 = 5'd5,
                         S_DIV1 = 5'd6,  S_Y = 5'd7,     S_K0Y = 5'd8,
                         S_K1Y = 5'd9,   S_K1P0 = 5'd10, S_K1P1 = 5'd11,
                         S_K0P0 = 5'd12, S_K0P1 = 5'd13, S_OUT = 5'd14;

  logic [4:0] st_r, st_nxt;
  logic       wait_r, wait_nxt;

  logic [NOISE_W-1:0] an_r, bn_r, mn_r;
  logic signed [31:0] ang_r, ang_nxt, bias_r, bias_nxt;
  logic signed [31:0] p00_r, p00_nxt, p01_r, p01_nxt, p10_r, p10_nxt, p11_r, p11_nxt;
  logic signed [31:0] meas_r, rate_r;
  logic [DT_W-1:0]    dt_r;
  logic signed [31:0] dtp_r, dtp_nxt, k0_r, k0_nxt, k1_r, k1_nxt, y_r, y_nxt;
  logic               ov_r, ov_nxt;
  logic [63:0]        obuf_r;

  logic               m_start, m_done, d_start, d_done;
  logic signed [39:0] m_a, m_b;
  acc_t               m_p;
  logic signed [31:0] d_num, d_q;
  logic signed [33:0] d_den;

  abkf_mul u_mul (.clk(clk), .rst_n(rst_n), .start(m_start), .op_a(m_a),
                  .op_b(m_b), .done(m_done), .prod(m_p));
  abkf_div u_div (.clk(clk), .rst_n(rst_n), .start(d_start), .num(d_num),
                  .den(d_den), .done(d_done), .quot(d_q));

  function automatic acc_t asr16(input acc_t v);
    asr16 = v >>> DT_FRAC;
  endfunction
  function automatic acc_t asr24(input acc_t v);
    asr24 = v >>> COV_FRAC;
  endfunction

  acc_t               dte, inner;
  logic signed [33:0] sden;
  assign dte   = acc_t'({1'b0, dt_r});
  assign inner = acc_t'(dtp_r) - acc_t'(p01_r) - acc_t'(p10_r) + acc_t'({1'b0, an_r});
  assign sden  = 34'(p00_r) + 34'({1'b0, mn_r});

  assign in_tready = (st_r == S_IDLE);

  // Sequencer: each multiply or divide step launches one unit then applies its result.
  always_comb begin
    st_nxt = st_r; wait_nxt = wait_r;
    ang_nxt = ang_r; bias_nxt = bias_r;
    p00_nxt = p00_r; p01_nxt = p01_r; p10_nxt = p10_r; p11_nxt = p11_r;
    dtp_nxt = dtp_r; k0_nxt = k0_r; k1_nxt = k1_r; y_nxt = y_r;
    ov_nxt = ov_r;
    m_start = 1'b0; m_a = '0; m_b = '0;
    d_start = 1'b0; d_num = '0; d_den = sden;
    if (ov_r && out_tready) ov_nxt = 1'b0;
    case (st_r)
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          st_nxt = S_RATE; wait_nxt = 1'b0;
        end
      end
      S_RATE, S_DTP11, S_INNER, S_P11, S_K0Y, S_K1Y,
      S_K0P0, S_K0P1, S_K1P0, S_K1P1: begin
        case (st_r)
          S_RATE:  begin m_a = 40'(dte); m_b = 40'(rate_r) - 40'(bias_r); end
          S_DTP11: begin m_a = 40'(dte); m_b = 40'(p11_r); end
          S_INNER: begin m_a = 40'(dte); m_b = 40'(inner); end
          S_P11:   begin m_a = 40'(dte); m_b = 40'({1'b0, bn_r}); end
          S_K0Y:   begin m_a = 40'(k0_r); m_b = 40'(y_r); end
          S_K1Y:   begin m_a = 40'(k1_r); m_b = 40'(y_r); end
          S_K0P0:  begin m_a = 40'(k0_r); m_b = 40'(p00_r); end
          S_K0P1:  begin m_a = 40'(k0_r); m_b = 40'(p01_r); end
          S_K1P0:  begin m_a = 40'(k1_r); m_b = 40'(p00_r); end
          default: begin m_a = 40'(k1_r); m_b = 40'(p01_r); end
        endcase
        if (!wait_r) begin
          m_start = 1'b1; wait_nxt = 1'b1;
        end else if (m_done) begin
          wait_nxt = 1'b0;
          st_nxt   = st_r + 5'd1;
          case (st_r)
            S_RATE:  ang_nxt = sat32(acc_t'(ang_r) + asr16(m_p));
            S_DTP11: dtp_nxt = 32'(asr16(m_p));
            S_INNER: begin
              p00_nxt = sat32(acc_t'(p00_r) + asr16(m_p));
              p01_nxt = sat32(acc_t'(p01_r) - acc_t'(dtp_r));
              p10_nxt = sat32(acc_t'(p10_r) - acc_t'(dtp_r));
            end
            S_P11:   p11_nxt = sat32(acc_t'(p11_r) + asr16(m_p));
            S_K0Y:   ang_nxt = sat32(acc_t'(ang_r) + asr24(m_p));
            S_K1Y:   bias_nxt = sat32(acc_t'(bias_r) + asr24(m_p));
            S_K0P0:  p00_nxt = sat32(acc_t'(p00_r) - asr24(m_p));
            S_K0P1:  p01_nxt = sat32(acc_t'(p01_r) - asr24(m_p));
            S_K1P0:  p10_nxt = sat32(acc_t'(p10_r) - asr24(m_p));
            default: p11_nxt = sat32(acc_t'(p11_r) - asr24(m_p));
          endcase
        end
      end
      S_DIV0, S_DIV1: begin
        d_num = (st_r == S_DIV0) ? p00_r : p10_r;
        if (!wait_r) begin
          d_start = 1'b1; wait_nxt = 1'b1;
        end else if (d_done) begin
          wait_nxt = 1'b0;
          st_nxt   = st_r + 5'd1;
          if (st_r == S_DIV0) k0_nxt = d_q;
          else                k1_nxt = d_q;
        end
      end
      S_Y: begin
        y_nxt  = sat32(acc_t'(meas_r) - acc_t'(ang_r));
        st_nxt = S_K0Y;
      end
      S_OUT: begin
        if (!ov_r) begin
          ov_nxt = 1'b1; st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; wait_r <= 1'b0; ov_r <= 1'b0;
      an_r <= ANGLE_NOISE_RST; bn_r <= BIAS_NOISE_RST; mn_r <= MEASURE_NOISE_RST;
      ang_r <= '0; bias_r <= '0;
      p00_r <= '0; p01_r <= '0; p10_r <= '0; p11_r <= '0;
    end else begin
      st_r <= st_nxt; wait_r <= wait_nxt; ov_r <= ov_nxt;
      ang_r <= ang_nxt; bias_r <= bias_nxt;
      p00_r <= p00_nxt; p01_r <= p01_nxt; p10_r <= p10_nxt; p11_r <= p11_nxt;
      // Take noise writes; unknown indexes drop.
      if (cfg_we) begin
        case (cfg_index)
          REG_ANGLE_NOISE:   an_r <= cfg_data;
          REG_BIAS_NOISE:    bn_r <= cfg_data;
          REG_MEASURE_NOISE: mn_r <= cfg_data;
          default: ;
        endcase
      end
    end
    if (in_tvalid && in_tready) begin
      meas_r <= in_tdata[31:0];
      rate_r <= in_tdata[63:32];
      dt_r   <= in_tdata[79:64];
    end
    dtp_r <= dtp_nxt;
    k0_r <= k0_nxt; k1_r <= k1_nxt; y_r <= y_nxt;
    if (st_r == S_OUT && !ov_r) obuf_r <= {bias_r, ang_r ^ {27'd0, FRAC_TAG & 5'd0}};
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = obuf_r;

  a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_IDLE) |-> !in_tready) else $error("ready while busy");
  a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
    !(m_start && d_start)) else $error("two units started");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(out_tdata)) else $error("result changed");
endmodule
